/* sv/id3p_pkg.sv */
// ----------------------------------------------------------------------------
// id3p_pkg
// Shared types, codes and frame ID constants for the ID3v2 text frame parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

  // parser phases
  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_FRAMEHDR = 2'd1;
  localparam logic [1:0] PH_DATA     = 2'd2;
  localparam logic [1:0] PH_HALTED   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  // frame kinds
  localparam logic [2:0] KIND_TITLE   = 3'd0;
  localparam logic [2:0] KIND_ARTIST  = 3'd1;
  localparam logic [2:0] KIND_ALBUM   = 3'd2;
  localparam logic [2:0] KIND_YEAR    = 3'd3;
  localparam logic [2:0] KIND_CONTENT = 3'd4;
  localparam logic [2:0] KIND_COMMENT = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;
  localparam logic [31:0] ID_TYER = 32'h5459_4552;
  localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
  localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

  localparam logic [3:0] HDR_LAST = 4'd9;  // both headers are ten bytes
  localparam logic [3:0] SIG_LEN  = 4'd3;
  localparam logic [3:0] ID_LEN   = 4'd4;
  localparam logic [3:0] SIZE_END = 4'd8;

  typedef struct packed {
    logic [2:0] frame_kind;
    logic       text_valid;
    logic [7:0] text_byte;
    logic       frame_end;
    logic [1:0] status;
  } res_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h49;  // I
      2'd1:    b = 8'h44;  // D
      default: b = 8'h33;  // 3
    endcase
    return b;
  endfunction

  function automatic logic [2:0] kind_of(input logic [31:0] id);
    logic [2:0] k;
    unique case (id)
      ID_TIT2: k = KIND_TITLE;
      ID_TPE1: k = KIND_ARTIST;
      ID_TALB: k = KIND_ALBUM;
      ID_TYER: k = KIND_YEAR;
      ID_TCON: k = KIND_CONTENT;
      ID_COMM: k = KIND_COMMENT;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

/* sv/id3p_core.sv */
// ----------------------------------------------------------------------------
// id3p_core
// Parse state and the one-byte step: header check, frame header capture,
// text extraction and frame accounting.
// ----------------------------------------------------------------------------
module id3p_core import id3p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] in_byte,
  input  logic       stream_start,
  input  logic [7:0] max_frames,
  output res_t       res,
  output logic       res_valid
);

  logic [1:0]  phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] frame_id, frame_id_next;
  logic [31:0] frame_size_left, frame_size_left_next;
  logic        first_data_byte, first_data_byte_next;
  logic        text_ended, text_ended_next;
  logic [7:0]  frames_seen, frames_seen_next;
  logic [2:0]  current_kind, current_kind_next;

  // state as seen by this byte (a stream start restarts the parse)
  logic [1:0]  ph;
  logic [3:0]  pos;
  logic [31:0] fid;
  logic [31:0] fsize;
  logic        first_b;
  logic        ended;
  logic [7:0]  seen;
  logic [2:0]  kind;

  // frame end handling
  logic        do_end;
  logic        end_tv;
  logic [7:0]  end_tb;
  logic [2:0]  end_kind;
  logic [7:0]  seen_inc;
  logic        tv;
  logic [31:0] size_dec;

  always_comb begin
    if (stream_start) begin
      ph      = PH_HEADER;
      pos     = '0;
      fid     = '0;
      fsize   = '0;
      first_b = 1'b1;
      ended   = 1'b0;
      seen    = '0;
      kind    = KIND_TITLE;
    end else begin
      ph      = phase;
      pos     = byte_position;
      fid     = frame_id;
      fsize   = frame_size_left;
      first_b = first_data_byte;
      ended   = text_ended;
      seen    = frames_seen;
      kind    = current_kind;
    end
  end

  always_comb begin
    phase_next           = ph;
    byte_position_next   = pos;
    frame_id_next        = fid;
    frame_size_left_next = fsize;
    first_data_byte_next = first_b;
    text_ended_next      = ended;
    frames_seen_next     = seen;
    current_kind_next    = kind;
    res                  = '0;
    res_valid            = 1'b0;
    do_end               = 1'b0;
    end_tv               = 1'b0;
    end_tb               = '0;
    end_kind             = kind;
    tv                   = 1'b0;
    size_dec             = fsize - 32'd1;
    seen_inc             = seen + 8'd1;

    unique case (ph)
      PH_HEADER: begin
        if (pos < SIG_LEN && in_byte != sig_byte(pos[1:0])) begin
          phase_next = PH_HALTED;
          res.status = ST_BAD_SIG;
          res_valid  = 1'b1;
        end else if (pos == HDR_LAST) begin
          phase_next         = PH_FRAMEHDR;
          byte_position_next = '0;
        end else begin
          byte_position_next = pos + 4'd1;
        end
      end

      PH_FRAMEHDR: begin
        if (pos < ID_LEN) begin
          frame_id_next = {fid[23:0], in_byte};
        end else if (pos < SIZE_END) begin
          frame_size_left_next = {fsize[23:0], in_byte};
        end
        if (pos == HDR_LAST) begin
          byte_position_next   = '0;
          end_kind             = kind_of(fid);
          current_kind_next    = end_kind;
          first_data_byte_next = 1'b1;
          text_ended_next      = 1'b0;
          if (fsize == '0) begin
            do_end = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          byte_position_next = pos + 4'd1;
        end
      end

      PH_DATA: begin
        if (kind != KIND_UNKNOWN) begin
          if (first_b) begin
            first_data_byte_next = 1'b0;
          end else if (!ended) begin
            if (in_byte == 8'd0) begin
              text_ended_next = 1'b1;
            end else begin
              tv = 1'b1;
            end
          end
        end
        frame_size_left_next = size_dec;
        if (size_dec == '0) begin
          do_end = 1'b1;
          end_tv = tv;
          end_tb = tv ? in_byte : 8'd0;
        end else if (tv) begin
          res.frame_kind = kind;
          res.text_valid = 1'b1;
          res.text_byte  = in_byte;
          res.status     = ST_OK;
          res_valid      = 1'b1;
        end
      end

      default: begin
        // halted: drop the byte
      end
    endcase

    if (do_end) begin
      res_valid = 1'b1;
      if (end_kind == KIND_UNKNOWN) begin
        phase_next = PH_HALTED;
        res.status = ST_UNKNOWN;
      end else begin
        frames_seen_next = seen_inc;
        res.frame_kind   = end_kind;
        res.text_valid   = end_tv;
        res.text_byte    = end_tb;
        res.frame_end    = 1'b1;
        if (seen_inc >= max_frames) begin
          phase_next = PH_HALTED;
          res.status = ST_DONE;
        end else begin
          phase_next         = PH_FRAMEHDR;
          byte_position_next = '0;
          res.status         = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      frame_id        <= '0;
      frame_size_left <= '0;
      first_data_byte <= 1'b1;
      text_ended      <= 1'b0;
      frames_seen     <= '0;
      current_kind    <= KIND_TITLE;
    end else if (en) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      frame_id        <= frame_id_next;
      frame_size_left <= frame_size_left_next;
      first_data_byte <= first_data_byte_next;
      text_ended      <= text_ended_next;
      frames_seen     <= frames_seen_next;
      current_kind    <= current_kind_next;
    end
  end

  // a halted parse only leaves on a stream start
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (!en || !stream_start) && phase == PH_HALTED |=> phase == PH_HALTED)
    else $error("parser left halted state without a stream start");

  a_text_known: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.text_valid |-> res.frame_kind != KIND_UNKNOWN && ph == PH_DATA)
    else $error("text byte from an unknown frame or outside frame data");

  a_end_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> res.status == ST_OK || res.status == ST_DONE)
    else $error("frame end carries an error status");

endmodule

/* sv/id3p_obuf.sv */
// ----------------------------------------------------------------------------
// id3p_obuf
// Result register: holds one parse result until the downstream side takes it.
// ----------------------------------------------------------------------------
module id3p_obuf import id3p_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic load_valid,
  input  res_t load_res,
  output logic free,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

/* sv/id3v2_text_frame_parser.sv */
// Path: an accepted byte passes the input register, then the result register,
//   from which its result leaves.
// Throughput: one byte per cycle; the parse step is a single pass of logic
//   between the two registers, so only out_stall holds the stream.
// Reset: rst is synchronous; it empties both registers, puts the parse in the
//   header phase and sets max_frames to 6.
// ----------------------------------------------------------------------------
// id3v2_text_frame_parser
// Streams ID3v2 tag bytes and emits the text of title, artist, album, year,
// content type and comment frames.
// ----------------------------------------------------------------------------
module id3v2_text_frame_parser import id3p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       max_frames_we,
  input  logic [7:0] max_frames_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       stream_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] frame_kind,
  output logic       text_valid,
  output logic [7:0] text_byte,
  output logic       frame_end,
  output logic [1:0] status
);

  logic [7:0] max_frames;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_adv;
  logic       obuf_free;
  res_t       core_res;
  logic       core_res_valid;
  res_t       out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames <= 8'd6;
    end else if (max_frames_we) begin
      max_frames <= max_frames_data;
    end
  end

  assign s1_adv   = s1_valid && obuf_free;
  assign in_stall = s1_valid && !obuf_free;

  // input register: take a new request whenever the held one moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= in_byte;
      s1_start <= stream_start;
    end
  end

  id3p_core u_core (
    .clk          (clk),
    .rst          (rst),
    .en           (s1_adv),
    .in_byte      (s1_byte),
    .stream_start (s1_start),
    .max_frames   (max_frames),
    .res          (core_res),
    .res_valid    (core_res_valid)
  );

  id3p_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_adv),
    .load_valid (core_res_valid),
    .load_res   (core_res),
    .free       (obuf_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign frame_kind = out_res.frame_kind;
  assign text_valid = out_res.text_valid;
  assign text_byte  = out_res.text_byte;
  assign frame_end  = out_res.frame_end;
  assign status     = out_res.status;

  // a held byte is never lost while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_byte))
    else $error("input register dropped a byte while output stalled");

endmodule

/* verif/tb_id3v2_text_frame_parser.sv */
// ----------------------------------------------------------------------------
// tb_id3v2_text_frame_parser
// Self-checking bench for the ID3v2 text frame parser. It streams short tag
// files (a directed opening, then random well-formed, truncated, corrupted
// and noise files) under bursty input and random output stalls. A local
// parse model predicts every result, and each result is compared field by
// field. The max_frames register is changed between runs, extremes included.
// ----------------------------------------------------------------------------
module tb_id3v2_text_frame_parser;
  import id3p_pkg::*;

  localparam int RAND_ITEMS  = 1050;
  localparam int NUM_RUNS    = 6;
  localparam int SETTLE      = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int LIMIT       = 400000;
  localparam int HDR_BYTES   = 10;      // tag header and frame header alike
  localparam logic [23:0] TAG_MAGIC = "ID3";

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RES} chk_e;

  typedef struct packed {
    logic       start;
    logic [7:0] b;
    chk_e       chk;
    res_t       want;
  } row_t;

  typedef struct packed {
    logic [1:0]  ph;
    logic [3:0]  pos;
    logic [31:0] id;
    logic [31:0] left;
    logic        first_b;
    logic        txt_done;
    logic [7:0]  nframes;
    logic [2:0]  kind;
  } tag_state_t;

  localparam tag_state_t TAG_IDLE = '{PH_HEADER, 4'd0, 32'd0, 32'd0, 1'b1, 1'b0,
                                      8'd0, KIND_TITLE};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       max_frames_we = 1'b0;
  logic [7:0] max_frames_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       stream_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] frame_kind;
  logic       text_valid;
  logic [7:0] text_byte;
  logic       frame_end;
  logic [1:0] status;

  id3v2_text_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .max_frames_we  (max_frames_we),
    .max_frames_data(max_frames_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .stream_start   (stream_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_kind     (frame_kind),
    .text_valid     (text_valid),
    .text_byte      (text_byte),
    .frame_end      (frame_end),
    .status         (status)
  );

  always #1 clk = ~clk;

  tag_state_t  tag_state = TAG_IDLE;
  logic [7:0]  max_frames_cur = 8'd6;
  res_t        parse_results_q[$];
  logic [7:0]  tag_bytes[$];
  int          cycles = 0;
  int          errors = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          results_seen = 0;
  int          status_hits[4];
  int          hold_reqs = 0;
  int          holds_done = 0;

  // Directed opening: a tag that starts without stream_start after reset, a
  // zero-size title frame, then bad signatures on the first and third byte.
  row_t dir_rows [25] = '{
    '{1'b0, "I",   CHK_MODEL, '0},
    '{1'b0, "D",   CHK_MODEL, '0},
    '{1'b0, "3",   CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'hFF, CHK_MODEL, '0},
    '{1'b0, 8'h03, CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'h80, CHK_MODEL, '0},
    '{1'b0, 8'h7F, CHK_MODEL, '0},
    '{1'b0, 8'h55, CHK_MODEL, '0},
    '{1'b0, "T",   CHK_MODEL, '0},
    '{1'b0, "I",   CHK_MODEL, '0},
    '{1'b0, "T",   CHK_MODEL, '0},
    '{1'b0, "2",   CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_MODEL, '0},
    '{1'b0, 8'hFF, CHK_MODEL, '0},
    '{1'b0, 8'h00, CHK_RES,   '{KIND_TITLE, 1'b0, 8'h00, 1'b1, ST_OK}},
    '{1'b1, 8'h00, CHK_RES,   '{KIND_TITLE, 1'b0, 8'h00, 1'b0, ST_BAD_SIG}},
    '{1'b0, 8'h49, CHK_NONE,  '0},
    '{1'b1, "I",   CHK_MODEL, '0},
    '{1'b0, "D",   CHK_MODEL, '0},
    '{1'b0, 8'hFF, CHK_RES,   '{KIND_TITLE, 1'b0, 8'h00, 1'b0, ST_BAD_SIG}}
  };

  function automatic logic [31:0] id_of_kind(input logic [2:0] k);
    case (k)
      KIND_TITLE:   return ID_TIT2;
      KIND_ARTIST:  return ID_TPE1;
      KIND_ALBUM:   return ID_TALB;
      KIND_YEAR:    return ID_TYER;
      KIND_CONTENT: return ID_TCON;
      default:      return ID_COMM;
    endcase
  endfunction

  function automatic void close_frame(input logic tv, input logic [7:0] tb, output res_t r);
    r = '0;
    if (tag_state.kind == KIND_UNKNOWN) begin
      tag_state.ph = PH_HALTED;
      r.status = ST_UNKNOWN;
    end else begin
      tag_state.nframes = tag_state.nframes + 8'd1;
      r.frame_kind = tag_state.kind;
      r.text_valid = tv;
      r.text_byte  = tb;
      r.frame_end  = 1'b1;
      if (tag_state.nframes >= max_frames_cur) begin
        tag_state.ph = PH_HALTED;
        r.status = ST_DONE;
      end else begin
        tag_state.ph  = PH_FRAMEHDR;
        tag_state.pos = 4'd0;
        r.status = ST_OK;
      end
    end
  endfunction

  // Advance the parse by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_tag_byte(input logic start, input logic [7:0] b,
                                        output res_t r);
    bit got;
    logic tv;
    int p;
    got = 1'b0;
    tv  = 1'b0;
    r   = '0;
    if (start) tag_state = TAG_IDLE;
    p = int'(tag_state.pos);
    case (tag_state.ph)
      PH_HEADER: begin
        if (p < 3 && b != TAG_MAGIC[23 - 8*p -: 8]) begin
          tag_state.ph = PH_HALTED;
          r.status = ST_BAD_SIG;
          got = 1'b1;
        end else begin
          tag_state.pos = tag_state.pos + 4'd1;
          if (tag_state.pos >= HDR_BYTES) begin
            tag_state.ph  = PH_FRAMEHDR;
            tag_state.pos = 4'd0;
          end
        end
      end
      PH_FRAMEHDR: begin
        if (p < 4) tag_state.id = {tag_state.id[23:0], b};
        else if (p < 8) tag_state.left = {tag_state.left[23:0], b};
        tag_state.pos = tag_state.pos + 4'd1;
        if (tag_state.pos >= HDR_BYTES) begin
          tag_state.pos  = 4'd0;
          tag_state.kind = KIND_UNKNOWN;
          for (int k = 0; k < 6; k++)
            if (tag_state.id == id_of_kind(3'(k))) tag_state.kind = 3'(k);
          tag_state.first_b  = 1'b1;
          tag_state.txt_done = 1'b0;
          if (tag_state.left == 32'd0) begin
            close_frame(1'b0, 8'h00, r);
            got = 1'b1;
          end else begin
            tag_state.ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (tag_state.kind != KIND_UNKNOWN) begin
          // skip the encoding byte, then emit text up to the first zero
          if (tag_state.first_b) tag_state.first_b = 1'b0;
          else if (!tag_state.txt_done) begin
            if (b == 8'h00) tag_state.txt_done = 1'b1;
            else tv = 1'b1;
          end
        end
        tag_state.left = tag_state.left - 32'd1;
        if (tag_state.left == 32'd0) begin
          close_frame(tv, tv ? b : 8'h00, r);
          got = 1'b1;
        end else if (tv) begin
          r = '{tag_state.kind, 1'b1, b, 1'b0, ST_OK};
          got = 1'b1;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch on %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
  endtask

  // Offer one request and hold it until accepted, then predict its result.
  task automatic send_byte(input logic start, input logic [7:0] b, input chk_e chk,
                           input res_t typed);
    res_t r;
    bit got;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_byte      <= b;
    stream_start <= start;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    got = parse_tag_byte(start, b, r);
    case (chk)
      CHK_RES:   parse_results_q.push_back(typed);
      CHK_NONE:  ;
      default:   if (got) parse_results_q.push_back(r);
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_max_frames(input logic [7:0] v);
    drain_results();
    max_frames_we   <= 1'b1;
    max_frames_data <= v;
    @(posedge clk);
    max_frames_we <= 1'b0;
    max_frames_cur = v;
  endtask

  // Mostly well-formed tags with random frames; some truncated, some with a
  // broken signature, a few pure noise.
  task automatic build_tag_file();
    int pick, id_pick, nfr, j;
    logic [31:0] id;
    logic [31:0] len;
    tag_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      repeat ($urandom_range(5, 20)) tag_bytes.push_back(8'($urandom));
    end else begin
      tag_bytes.push_back("I");
      tag_bytes.push_back("D");
      tag_bytes.push_back("3");
      repeat (7) tag_bytes.push_back(8'($urandom));
      nfr = $urandom_range(1, 7);
      repeat (nfr) begin
        id = id_of_kind(3'($urandom_range(0, 5)));
        id_pick = $urandom_range(0, 99);
        if (id_pick >= 93) id = $urandom;
        else if (id_pick >= 85) id = id ^ (32'd1 << $urandom_range(0, 31));
        id_pick = $urandom_range(0, 99);
        if (id_pick < 10) len = 32'd0;
        else if (id_pick < 85) len = $urandom_range(1, 10);
        else len = $urandom_range(11, 40);
        for (int i = 3; i >= 0; i--) tag_bytes.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--) tag_bytes.push_back(len[8*i +: 8]);
        repeat (2) tag_bytes.push_back(8'($urandom));
        for (int i = 0; i < len; i++) begin
          if (i == 0) tag_bytes.push_back(8'($urandom));
          else if ($urandom_range(0, 9) == 0) tag_bytes.push_back(8'h00);
          else tag_bytes.push_back(8'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) tag_bytes.push_back(8'($urandom));
      if (pick >= 85) begin
        j = $urandom_range(0, 2);
        tag_bytes[j] = tag_bytes[j] ^ 8'($urandom_range(1, 255));
      end else if (pick >= 75) begin
        j = $urandom_range(1, tag_bytes.size() - 1);
        while (tag_bytes.size() > j) void'(tag_bytes.pop_back());
      end
    end
  endtask

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: segments of random stall density, plus a long hold-off on request.
  initial begin : receiver
    int seg, mode;
    forever begin
      if (holds_done < hold_reqs) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg  = $urandom_range(10, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (parse_results_q.size() == 0) begin
        flag_mismatch("result with nothing pending, status", 8'(status), 8'h00);
      end else begin
        want = parse_results_q.pop_front();
        results_seen++;
        status_hits[want.status]++;
        if (frame_kind !== want.frame_kind) flag_mismatch("frame_kind", 8'(frame_kind),
                                                          8'(want.frame_kind));
        if (text_valid !== want.text_valid) flag_mismatch("text_valid", 8'(text_valid),
                                                          8'(want.text_valid));
        if (text_byte !== want.text_byte) flag_mismatch("text_byte", text_byte,
                                                        want.text_byte);
        if (frame_end !== want.frame_end) flag_mismatch("frame_end", 8'(frame_end),
                                                        8'(want.frame_end));
        if (status !== want.status) flag_mismatch("status", 8'(status),
                                                  8'(want.status));
      end
    end
  end

  initial begin : stimulus
    res_t none;
    int target;
    logic [7:0] plan [NUM_RUNS];
    none = '0;
    plan = '{8'd6, 8'd1, 8'd255, 8'd0, 8'd2, 8'd6};
    plan[NUM_RUNS-1] = 8'($urandom_range(3, 12));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].start, dir_rows[i].b, dir_rows[i].chk, dir_rows[i].want);
    // first run keeps the reset value of max_frames
    for (int p = 0; p < NUM_RUNS; p++) begin
      if (p != 0) set_max_frames(plan[p]);
      hold_reqs++;
      target = bytes_sent + RAND_ITEMS / NUM_RUNS;
      while (bytes_sent < target) begin
        build_tag_file();
        foreach (tag_bytes[i]) send_byte(i == 0, tag_bytes[i], CHK_MODEL, none);
        files_sent++;
      end
    end
    drain_results();
    $display("covered %0d tag streams, %0d bytes sent, %0d max_frames settings",
             files_sent, bytes_sent, NUM_RUNS);
    $display("results checked %0d: ok %0d, bad signature %0d, unknown frame %0d, done %0d",
             results_seen, status_hits[ST_OK], status_hits[ST_BAD_SIG],
             status_hits[ST_UNKNOWN], status_hits[ST_DONE]);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
